>>> rtl/core/wsfcp_pkg.sv
// Shared constants for the wheel speed from capture period block.
package wsfcp_pkg;

    localparam int SAMPLE_COUNT = 4;
    localparam int IDX_W        = $clog2(SAMPLE_COUNT);

    localparam int TS_W    = 32;
    localparam int CLK_W   = 28;
    localparam int MPP_W   = 32;
    localparam int SUM_W   = TS_W + $clog2(SAMPLE_COUNT - 1);
    localparam int NUM_W   = CLK_W + $clog2(SAMPLE_COUNT);
    localparam int FREQ_W  = 30;
    localparam int SPEED_W = 32;
    localparam int PROD_W  = NUM_W + MPP_W;
    localparam int FRAC_W  = 16;

    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METRES_PER_PULSE = 1'd1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd200000000;
    localparam logic [MPP_W-1:0] MPP_RESET = 32'd111317561;

endpackage

>>> rtl/core/wheel_speed_from_capture_period.sv
// Wheel speed from capture timestamps: sample buffer, period sum, serial divide, scale.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_operation, i_timestamp
//  output   | o_out_valid / i_out_ready  | o_speed_q16, o_pulse_freq_hz, o_moving,
//           |                            | o_divide_fault
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A capture item gives no result.
// A tick runs a compare pass and a sum pass over the snapshot, 30 restoring divide steps,
// one multiply and one output step; the divider resolves one quotient bit per cycle.
// An unchanged snapshot finishes after the compare pass; a zero sum after the sum pass.
// o_in_ready is low while a tick is in work and while its result waits for a free
// output register. Reset is synchronous, active low, returns configuration to its reset
// values and clears sample and snapshot state at once.
module wheel_speed_from_capture_period (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_operation,
    input  logic [wsfcp_pkg::TS_W-1:0]             i_timestamp,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [wsfcp_pkg::SPEED_W-1:0]          o_speed_q16,
    output logic [wsfcp_pkg::FREQ_W-1:0]           o_pulse_freq_hz,
    output logic                                   o_moving,
    output logic                                   o_divide_fault,
    input  logic                                   i_cfg_we,
    input  logic [wsfcp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wsfcp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_SUM  = 6'b000100,
        S_DIV  = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    localparam logic [wsfcp_pkg::IDX_W-1:0] IDX_LAST =
        wsfcp_pkg::IDX_W'(wsfcp_pkg::SAMPLE_COUNT - 1);
    localparam logic [wsfcp_pkg::DIV_CNT_W-1:0] DIV_LAST =
        wsfcp_pkg::DIV_CNT_W'(wsfcp_pkg::DIV_STEPS - 1);

    t_state                               r_state, n_state;
    logic [wsfcp_pkg::CLK_W-1:0]          r_clk_hz;
    logic [wsfcp_pkg::MPP_W-1:0]          r_mpp;
    logic [wsfcp_pkg::TS_W-1:0]           r_fill [wsfcp_pkg::SAMPLE_COUNT];
    logic [wsfcp_pkg::IDX_W-1:0]          r_fill_cnt;
    logic [wsfcp_pkg::TS_W-1:0]           r_snap [wsfcp_pkg::SAMPLE_COUNT];
    logic [wsfcp_pkg::TS_W-1:0]           r_prev [wsfcp_pkg::SAMPLE_COUNT];
    logic [wsfcp_pkg::IDX_W-1:0]          r_idx;
    logic [wsfcp_pkg::TS_W-1:0]           r_last;
    logic [wsfcp_pkg::SUM_W-1:0]          r_acc;
    logic [wsfcp_pkg::SUM_W-1:0]          r_rem;
    logic [wsfcp_pkg::NUM_W-1:0]          r_quo;
    logic [wsfcp_pkg::DIV_CNT_W-1:0]      r_div_cnt;
    logic [wsfcp_pkg::PROD_W-1:0]         r_prod;
    logic                                 r_res_moving;
    logic                                 r_res_fault;
    logic                                 r_out_valid;
    logic [wsfcp_pkg::SPEED_W-1:0]        r_speed;
    logic [wsfcp_pkg::FREQ_W-1:0]         r_freq;
    logic                                 r_moving;
    logic                                 r_fault;

    logic [wsfcp_pkg::TS_W-1:0]           diff;
    logic [wsfcp_pkg::SUM_W-1:0]          n_acc;
    logic [wsfcp_pkg::SUM_W:0]            div_trial;
    logic [wsfcp_pkg::SUM_W+1:0]          div_sub;
    logic                                 div_ge;
    logic [wsfcp_pkg::NUM_W-1:0]          numer;
    logic [wsfcp_pkg::SPEED_W-1:0]        speed_sat;
    logic                                 snap_ne;
    logic                                 out_ld;
    logic                                 in_acc;

    assign o_in_ready      = (r_state == S_IDLE);
    assign in_acc          = i_in_valid && o_in_ready;
    assign out_ld          = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_speed_q16     = r_speed;
    assign o_pulse_freq_hz = r_freq;
    assign o_moving        = r_moving;
    assign o_divide_fault  = r_fault;

    always_comb begin
        diff      = r_snap[r_idx] - r_last;
        n_acc     = r_acc + wsfcp_pkg::SUM_W'(diff);
        snap_ne   = (r_snap[r_idx] != r_prev[r_idx]);
        div_trial = {r_rem, r_quo[wsfcp_pkg::NUM_W-1]};
        div_sub   = {1'b0, div_trial} - {2'b00, r_acc};
        div_ge    = !div_sub[wsfcp_pkg::SUM_W+1];
        numer     = wsfcp_pkg::NUM_W'(r_clk_hz)
                  * wsfcp_pkg::NUM_W'(wsfcp_pkg::SAMPLE_COUNT - 1);
        if (|r_prod[wsfcp_pkg::PROD_W-1:wsfcp_pkg::FRAC_W+wsfcp_pkg::SPEED_W]) begin
            speed_sat = '1;
        end else begin
            speed_sat = r_prod[wsfcp_pkg::FRAC_W+wsfcp_pkg::SPEED_W-1:wsfcp_pkg::FRAC_W];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_operation == wsfcp_pkg::OP_TICK) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (snap_ne) begin
                    n_state = S_SUM;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_SUM: begin
                if (r_idx == IDX_LAST) begin
                    n_state = (n_acc == '0) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_ld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clk_hz    <= wsfcp_pkg::CLK_RESET;
            r_mpp       <= wsfcp_pkg::MPP_RESET;
            r_fill_cnt  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < wsfcp_pkg::SAMPLE_COUNT; k++) begin
                r_fill[k] <= '0;
                r_snap[k] <= '0;
                r_prev[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    wsfcp_pkg::CFG_TIMER_CLOCK_HZ: begin
                        r_clk_hz <= i_cfg_data[wsfcp_pkg::CLK_W-1:0];
                    end
                    wsfcp_pkg::CFG_METRES_PER_PULSE: begin
                        r_mpp <= i_cfg_data[wsfcp_pkg::MPP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_FIN && out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (in_acc && i_operation == wsfcp_pkg::OP_CAPTURE) begin
                        r_fill[r_fill_cnt] <= i_timestamp;
                        if (r_fill_cnt == IDX_LAST) begin
                            r_fill_cnt <= '0;
                            for (int k = 0; k < wsfcp_pkg::SAMPLE_COUNT; k++) begin
                                if (k == wsfcp_pkg::SAMPLE_COUNT - 1) begin
                                    r_snap[k] <= i_timestamp;
                                end else begin
                                    r_snap[k] <= r_fill[k];
                                end
                            end
                        end else begin
                            r_fill_cnt <= r_fill_cnt + 1'b1;
                        end
                    end
                end
                S_CMP: begin
                    if (snap_ne) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_res_moving <= 1'b0;
                    r_res_fault  <= 1'b0;
                end
                S_SUM: begin
                    r_prev[r_idx] <= r_snap[r_idx];
                    r_last        <= r_snap[r_idx];
                    r_acc         <= (r_idx == '0) ? '0 : n_acc;
                    r_idx         <= r_idx + 1'b1;
                    r_res_moving  <= 1'b1;
                    r_res_fault   <= (n_acc == '0);
                    r_quo         <= numer;
                    r_rem         <= '0;
                    r_div_cnt     <= '0;
                end
                S_DIV: begin
                    r_quo     <= {r_quo[wsfcp_pkg::NUM_W-2:0], div_ge};
                    r_rem     <= div_ge ? div_sub[wsfcp_pkg::SUM_W-1:0]
                                        : div_trial[wsfcp_pkg::SUM_W-1:0];
                    r_div_cnt <= r_div_cnt + 1'b1;
                end
                S_MUL: begin
                    r_prod <= wsfcp_pkg::PROD_W'(r_quo) * wsfcp_pkg::PROD_W'(r_mpp);
                end
                S_FIN: begin
                    if (out_ld) begin
                        r_moving <= r_res_moving;
                        r_fault  <= r_res_fault;
                        if (r_res_moving && !r_res_fault) begin
                            r_speed <= speed_sat;
                            r_freq  <= wsfcp_pkg::FREQ_W'(r_quo);
                        end else begin
                            r_speed <= '0;
                            r_freq  <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_fault_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fault |-> r_moving)
        else $error("divide fault reported without snapshot change");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (!r_moving || r_fault) |-> (r_speed == '0 && r_freq == '0))
        else $error("nonzero speed on a stationary or faulted result");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_cnt <= DIV_LAST)
        else $error("divide step count out of range");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside the final step");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SUM) |-> !o_in_ready)
        else $error("input ready while a tick is in work");
`endif

endmodule

>>> test/wheel_speed_from_capture_period_checker.sv
// Checker for the wheel speed block: tracks its capture state, predicts each tick report, compares.
module wheel_speed_from_capture_period_checker
    import wsfcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_operation,
    input  logic [TS_W-1:0]       i_timestamp,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SPEED_W-1:0]    i_speed_q16,
    input  logic [FREQ_W-1:0]     i_pulse_freq_hz,
    input  logic                  i_moving,
    input  logic                  i_divide_fault,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FREQ_LIMIT  = (64'd1 << FREQ_W) - 64'd1;
    localparam logic [63:0] SPEED_LIMIT = (64'd1 << SPEED_W) - 64'd1;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q16;
        logic [FREQ_W-1:0]  pulse_freq_hz;
        logic               moving;
        logic               divide_fault;
    } t_speed_report;

    t_speed_report   report_q[$];
    logic [TS_W-1:0] fill_buf      [SAMPLE_COUNT];
    logic [TS_W-1:0] snapshot      [SAMPLE_COUNT];
    logic [TS_W-1:0] last_snapshot [SAMPLE_COUNT];
    int unsigned     fill_pos;
    logic [CLK_W-1:0] timer_hz;
    logic [MPP_W-1:0] travel_per_pulse;
    int              mismatches = 0;

    function automatic t_speed_report estimate_speed();
        t_speed_report   rep;
        logic            changed;
        logic [TS_W-1:0] gap;
        logic [63:0]     period_total;
        logic [63:0]     freq;
        logic [63:0]     speed;
        rep = '0;
        changed = 1'b0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (snapshot[i] != last_snapshot[i]) changed = 1'b1;
        end
        if (!changed) return rep;
        period_total = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            last_snapshot[i] = snapshot[i];
        end
        for (int i = 0; i + 1 < SAMPLE_COUNT; i++) begin
            gap = snapshot[i+1] - snapshot[i];
            period_total = period_total + 64'(gap);
        end
        rep.moving = 1'b1;
        if (period_total == 0) begin
            rep.divide_fault = 1'b1;
            return rep;
        end
        freq = (64'(SAMPLE_COUNT - 1) * 64'(timer_hz)) / period_total;
        if (freq > FREQ_LIMIT) freq = FREQ_LIMIT;
        speed = (freq * 64'(travel_per_pulse)) >> FRAC_W;
        if (speed > SPEED_LIMIT) speed = SPEED_LIMIT;
        rep.speed_q16     = speed[SPEED_W-1:0];
        rep.pulse_freq_hz = freq[FREQ_W-1:0];
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_speed_report want;
        if (!i_rst_n) begin
            report_q.delete();
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                fill_buf[i]      = '0;
                snapshot[i]      = '0;
                last_snapshot[i] = '0;
            end
            fill_pos         = 0;
            timer_hz         = CLK_RESET;
            travel_per_pulse = MPP_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMER_CLOCK_HZ:   timer_hz = i_cfg_data[CLK_W-1:0];
                    CFG_METRES_PER_PULSE: travel_per_pulse = i_cfg_data[MPP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_TICK) begin
                    report_q.push_back(estimate_speed());
                end else begin
                    fill_buf[fill_pos] = i_timestamp;
                    if (fill_pos == SAMPLE_COUNT - 1) begin
                        for (int i = 0; i < SAMPLE_COUNT; i++) snapshot[i] = fill_buf[i];
                        fill_pos = 0;
                    end else begin
                        fill_pos++;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    $error("speed report with no tick outstanding");
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    check_field("speed_q16", 64'(want.speed_q16), 64'(i_speed_q16));
                    check_field("pulse_freq_hz", 64'(want.pulse_freq_hz),
                                64'(i_pulse_freq_hz));
                    check_field("moving", 64'(want.moving), 64'(i_moving));
                    check_field("divide_fault", 64'(want.divide_fault),
                                64'(i_divide_fault));
                end
            end
        end
        o_pending    <= report_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> test/wheel_speed_from_capture_period_tb.sv
// Testbench top for the wheel speed block: clock, reset, item stimulus, sink stalls and verdict.
module wheel_speed_from_capture_period_tb;
    import wsfcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int ITEMS_PER_SETUP  = 260;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 60;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef enum {SINK_FREE, SINK_MOSTLY_READY, SINK_MOSTLY_STALLED, SINK_PATTERN} t_sink_mode;
    typedef logic [SAMPLE_COUNT-1:0][TS_W-1:0] t_stamp_set;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_CAPTURE;
    logic [TS_W-1:0]       timestamp = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPEED_W-1:0]    speed_q16;
    logic [FREQ_W-1:0]     pulse_freq_hz;
    logic                  moving;
    logic                  divide_fault;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMER_CLOCK_HZ;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    pending;
    int                    fail_count;

    int          burst_left    = 0;
    int          items_sent    = 0;
    int unsigned capture_phase = 0;
    logic        hold_off_req  = 1'b0;
    t_stamp_set  last_snap     = '0;

    wheel_speed_from_capture_period dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_operation     (operation),
        .i_timestamp     (timestamp),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_speed_q16     (speed_q16),
        .o_pulse_freq_hz (pulse_freq_hz),
        .o_moving        (moving),
        .o_divide_fault  (divide_fault),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    wheel_speed_from_capture_period_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_operation     (operation),
        .i_timestamp     (timestamp),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_speed_q16     (speed_q16),
        .i_pulse_freq_hz (pulse_freq_hz),
        .i_moving        (moving),
        .i_divide_fault  (divide_fault),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(input logic op, input logic [TS_W-1:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        in_valid  <= 1'b1;
        operation <= op;
        timestamp <= ts;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        items_sent++;
        if (op == OP_CAPTURE) capture_phase = (capture_phase + 1) % SAMPLE_COUNT;
    endtask

    // pads any partial fill so the given stamps land as one whole snapshot
    task automatic send_snapshot(input t_stamp_set stamps);
        while (capture_phase != 0) send_item(OP_CAPTURE, $urandom());
        for (int k = 0; k < SAMPLE_COUNT; k++) send_item(OP_CAPTURE, stamps[k]);
        last_snap = stamps;
    endtask

    task automatic pulse_train();
        t_stamp_set      stamps;
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] jitter;
        logic [TS_W-1:0] stamp;
        case ($urandom_range(0, 3))
            0:       period = $urandom_range(0, 3);
            1:       period = $urandom_range(4, 4095);
            2:       period = $urandom_range(4096, 32'h00FF_FFFF);
            default: period = $urandom();
        endcase
        jitter = (period < 32'h0100_0000) ? (period >> 3) : '0;
        stamp  = $urandom();
        for (int k = 0; k < SAMPLE_COUNT; k++) begin
            stamps[k] = stamp;
            stamp = stamp + period + $urandom_range(0, jitter);
        end
        send_snapshot(stamps);
    endtask

    task automatic random_episode();
        int              pick;
        logic [TS_W-1:0] level;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            pulse_train();
            repeat ($urandom_range(1, 2)) send_item(OP_TICK, $urandom());
        end else if (pick < 68) begin
            level = $urandom();
            send_snapshot({SAMPLE_COUNT{level}});
            send_item(OP_TICK, $urandom());
        end else if (pick < 76) begin
            send_snapshot(last_snap);
            send_item(OP_TICK, $urandom());
        end else if (pick < 86) begin
            send_item(OP_TICK, $urandom());
        end else begin
            repeat ($urandom_range(1, 3)) send_item(logic'($urandom_range(0, 1)), $urandom());
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) random_episode();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] clock_hz,
                              input logic [CFG_DATA_W-1:0] travel);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMER_CLOCK_HZ;
        cfg_data  <= clock_hz;
        @(posedge clk);
        cfg_index <= CFG_METRES_PER_PULSE;
        cfg_data  <= travel;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_TICK, 32'hFFFF_FFFF);
        send_snapshot({SAMPLE_COUNT{32'hFFFF_FFFF}});
        send_item(OP_TICK, 32'h0000_0000);
        send_item(OP_TICK, $urandom());
        send_snapshot({32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE});
        send_item(OP_TICK, $urandom());
        send_snapshot({32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000});
        send_item(OP_TICK, $urandom());
        send_item(OP_CAPTURE, 32'h5555_5555);
        send_item(OP_CAPTURE, 32'hAAAA_AAAA);
        send_item(OP_TICK, $urandom());
        send_item(OP_CAPTURE, 32'hAAAB_0000);
        send_item(OP_CAPTURE, 32'hAAAB_5555);
        send_item(OP_TICK, $urandom());

        run_random(ITEMS_PER_SETUP);
        drain();
        set_config(32'h0FFF_FFFF, 32'hFFFF_FFFF);
        hold_off_req <= 1'b1;
        run_random(ITEMS_PER_SETUP);
        drain();
        set_config('0, $urandom());
        run_random(ITEMS_PER_SETUP);
        drain();
        set_config(32'd1, '0);
        run_random(ITEMS_PER_SETUP);
        drain();
        // upper data bits fall outside the clock register
        set_config($urandom(), $urandom());
        run_random(ITEMS_PER_SETUP);
        drain();
        set_config($urandom_range(1000, 200_000_000), $urandom());
        run_random(ITEMS_PER_SETUP);
        drain();
        set_config(32'd200_000_000, 32'd1);
        run_random(ITEMS_PER_SETUP);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : sink
        t_sink_mode mode;
        int         span;
        logic [7:0] pattern;
        logic       held;
        held = 1'b0;
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                repeat (LONG_HOLD_CYCLES) begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
            end
            mode    = t_sink_mode'($urandom_range(0, 3));
            span    = $urandom_range(20, 200);
            pattern = $urandom();
            for (int k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    SINK_FREE:           out_ready <= 1'b1;
                    SINK_MOSTLY_READY:   out_ready <= ($urandom_range(0, 3) != 0);
                    SINK_MOSTLY_STALLED: out_ready <= ($urandom_range(0, 3) == 0);
                    default:             out_ready <= pattern[k % 8];
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
